// ===== design/ilha_pkg.sv =====
// shared types and constants of the boundary-tag heap allocator
package ilha_pkg;

  localparam int BYTE_W = 17;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam byte_t MIN_BLOCK     = byte_t'(16);
  localparam byte_t FIRST_PAYLOAD = byte_t'(16);
  localparam int    CHUNK_RESET   = 4096;

  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_INIT4,
    S_IDLE,
    S_AWALK_RD, S_AWALK_CHK,
    S_GROW, S_GW0, S_GW1, S_GW2,
    S_MPREV, S_MNEXT, S_MCALC, S_MW0, S_MW1,
    S_PW0, S_PW1, S_PW2, S_PW3,
    S_FWALK_RD, S_FWALK_CHK, S_FW0, S_FW1,
    S_DONE
  } state_t;

endpackage

// ===== design/ilha_chan_if.sv =====
// valid/ready channel carrying one payload beat
interface ilha_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/implicit_list_heap_allocator_unit.sv =====
// boundary-tag first-fit heap allocator with one word memory
//
//   channel | dir | payload                                 | beat
//   req     | in  | func, request_bytes, block_offset       | one allocate or free
//   rsp     | out | payload_offset, status                  | one result per req
//   cfg     | in  | chunk_bytes (17 bits)                   | one register write
//
// a grow writes a free block and epilogue and merges; a merge reads both
// neighbours and rewrites the tags; a split makes four writes. the single
// memory port (one access per cycle) sets the pace. after reset S_INIT0 to
// S_INIT4 build the prologue, epilogue and first chunk while req is held
// off. a stalled rsp holds its beat; the next req is still taken.
module implicit_list_heap_allocator_unit #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic   clk,
  input  logic   rst,
  ilha_chan_if.sink   req,
  ilha_chan_if.source rsp,
  ilha_chan_if.sink   cfg
);
  import ilha_pkg::*;

  localparam int AW        = $clog2(HEAP_WORDS);
  localparam int LIMIT     = (HEAP_WORDS * 4 > 65536) ? 65536 : HEAP_WORDS * 4;
  localparam int INIT_ROOM = (LIMIT - 16) & ~7;
  localparam int INIT_CLIP = (CHUNK_RESET > INIT_ROOM) ? INIT_ROOM : CHUNK_RESET;
  localparam int INIT_WANT = (INIT_CLIP < 16) ? 0 : INIT_CLIP;
  localparam byte_t INIT_W   = byte_t'(INIT_WANT);
  localparam byte_t INIT_TOP = byte_t'(16 + INIT_WANT);
  localparam logic [BYTE_W:0] LIM = (BYTE_W+1)'(LIMIT);

  logic [31:0] mem [HEAP_WORDS];
  logic [31:0] rdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   mem_wdata;

  state_t state, state_next;
  byte_t bp, bp_next;
  byte_t sz, sz_next;
  byte_t asize, asize_next;
  byte_t top, top_next;
  byte_t prev_sz, prev_sz_next;
  logic  prev_free, prev_free_next;
  logic  grow_mode, grow_mode_next;
  logic [15:0] off, off_next;
  logic [15:0] res_off, res_off_next;
  logic [1:0]  res_st, res_st_next;
  byte_t chunk;
  logic  out_valid, out_valid_next;
  rsp_t  out_data, out_data_next;

  function automatic logic [AW-1:0] waddr(byte_t b);
    logic [31:0] t;
    t = 32'(b) >> 2;
    return AW'(t);
  endfunction

  function automatic byte_t tag_size(logic [31:0] t);
    return {t[16:3], 3'b000};
  endfunction

  function automatic logic [31:0] tag(byte_t s, logic a);
    return 32'(s) | 32'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      top       <= INIT_TOP;
      chunk     <= byte_t'(CHUNK_RESET);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      top       <= top_next;
      out_valid <= out_valid_next;
      if (cfg.valid) begin
        chunk <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bp        <= bp_next;
    sz        <= sz_next;
    asize     <= asize_next;
    prev_sz   <= prev_sz_next;
    prev_free <= prev_free_next;
    grow_mode <= grow_mode_next;
    off       <= off_next;
    res_off   <= res_off_next;
    res_st    <= res_st_next;
    out_data  <= out_data_next;
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    byte_t rsz;
    byte_t nsz;
    byte_t msize;
    byte_t rem;
    logic [BYTE_W:0] grow_by;
    logic [BYTE_W:0] room;
    logic [BYTE_W:0] want;

    state_next     = state;
    bp_next        = bp;
    sz_next        = sz;
    asize_next     = asize;
    top_next       = top;
    prev_sz_next   = prev_sz;
    prev_free_next = prev_free;
    grow_mode_next = grow_mode;
    off_next       = off;
    res_off_next   = res_off;
    res_st_next    = res_st;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    mem_addr       = waddr(bp - byte_t'(4));
    mem_we         = 1'b0;
    mem_wdata      = '0;

    rsz     = tag_size(rdata);
    rem     = sz - asize;
    msize   = sz;
    nsz     = '0;
    grow_by = ((BYTE_W+1)'(chunk) + (BYTE_W+1)'(7)) & ~(BYTE_W+1)'(7);
    if ((BYTE_W+1)'(asize) > grow_by) begin
      grow_by = (BYTE_W+1)'(asize);
    end
    room = (LIM > (BYTE_W+1)'(top)) ? ((LIM - (BYTE_W+1)'(top)) & ~(BYTE_W+1)'(7)) : '0;
    want = (grow_by > room) ? room : grow_by;

    if (rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_INIT0: begin
        mem_addr   = waddr(byte_t'(4));
        mem_we     = 1'b1;
        mem_wdata  = tag(byte_t'(8), 1'b1);
        state_next = S_INIT1;
      end
      S_INIT1: begin
        mem_addr   = waddr(byte_t'(8));
        mem_we     = 1'b1;
        mem_wdata  = tag(byte_t'(8), 1'b1);
        state_next = S_INIT2;
      end
      S_INIT2: begin
        mem_addr   = waddr(byte_t'(12));
        mem_we     = 1'b1;
        mem_wdata  = (INIT_WANT != 0) ? tag(INIT_W, 1'b0) : tag('0, 1'b1);
        state_next = (INIT_WANT != 0) ? S_INIT3 : S_IDLE;
      end
      S_INIT3: begin
        mem_addr   = waddr(INIT_TOP - byte_t'(8));
        mem_we     = 1'b1;
        mem_wdata  = tag(INIT_W, 1'b0);
        state_next = S_INIT4;
      end
      S_INIT4: begin
        mem_addr   = waddr(INIT_TOP - byte_t'(4));
        mem_we     = 1'b1;
        mem_wdata  = tag('0, 1'b1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          bp_next      = FIRST_PAYLOAD;
          off_next     = req.data.block_offset;
          res_off_next = '0;
          res_st_next  = ST_OK;
          asize_next   = (req.data.request_bytes <= 16'd8) ? MIN_BLOCK :
                         ((byte_t'(req.data.request_bytes) + byte_t'(15)) & ~byte_t'(7));
          if (req.data.func == FUNC_FREE) begin
            state_next = S_FWALK_RD;
          end else if (req.data.request_bytes == '0) begin
            res_st_next = ST_ZERO;
            state_next  = S_DONE;
          end else begin
            state_next = S_AWALK_RD;
          end
        end
      end
      S_AWALK_RD: begin
        state_next = (bp >= top) ? S_GROW : S_AWALK_CHK;
      end
      S_AWALK_CHK: begin
        if (rsz < byte_t'(8)) begin
          state_next = S_GROW;
        end else if (!rdata[0] && rsz >= asize) begin
          sz_next    = rsz;
          state_next = S_PW0;
        end else begin
          bp_next    = bp + rsz;
          state_next = S_AWALK_RD;
        end
      end
      S_GROW: begin
        if (want < (BYTE_W+1)'(MIN_BLOCK)) begin
          res_st_next = ST_OOM;
          state_next  = S_DONE;
        end else begin
          bp_next    = top;
          sz_next    = byte_t'(want);
          state_next = S_GW0;
        end
      end
      S_GW0: begin
        mem_we     = 1'b1;
        mem_wdata  = tag(sz, 1'b0);
        state_next = S_GW1;
      end
      S_GW1: begin
        mem_addr   = waddr(bp + sz - byte_t'(8));
        mem_we     = 1'b1;
        mem_wdata  = tag(sz, 1'b0);
        state_next = S_GW2;
      end
      S_GW2: begin
        mem_addr       = waddr(bp + sz - byte_t'(4));
        mem_we         = 1'b1;
        mem_wdata      = tag('0, 1'b1);
        top_next       = bp + sz;
        grow_mode_next = 1'b1;
        state_next     = S_MPREV;
      end
      S_MPREV: begin
        mem_addr   = waddr(bp - byte_t'(8));
        state_next = S_MNEXT;
      end
      S_MNEXT: begin
        prev_sz_next   = rsz;
        prev_free_next = !rdata[0];
        mem_addr       = waddr(bp + sz - byte_t'(4));
        state_next     = S_MCALC;
      end
      S_MCALC: begin
        nsz = rsz;
        if (!rdata[0] && nsz >= byte_t'(8)) begin
          msize = msize + nsz;
        end
        if (prev_free && prev_sz >= byte_t'(8) && prev_sz <= bp) begin
          bp_next = bp - prev_sz;
          msize   = msize + prev_sz;
        end
        sz_next    = msize;
        state_next = S_MW0;
      end
      S_MW0: begin
        mem_we     = 1'b1;
        mem_wdata  = tag(sz, 1'b0);
        state_next = S_MW1;
      end
      S_MW1: begin
        mem_addr  = waddr(bp + sz - byte_t'(8));
        mem_we    = 1'b1;
        mem_wdata = tag(sz, 1'b0);
        if (!grow_mode) begin
          state_next = S_DONE;
        end else if (sz < asize) begin
          res_st_next = ST_OOM;
          state_next  = S_DONE;
        end else begin
          state_next = S_PW0;
        end
      end
      S_PW0: begin
        mem_we     = 1'b1;
        mem_wdata  = (rem >= MIN_BLOCK) ? tag(asize, 1'b1) : tag(sz, 1'b1);
        state_next = S_PW1;
      end
      S_PW1: begin
        mem_we = 1'b1;
        if (rem >= MIN_BLOCK) begin
          mem_addr   = waddr(bp + asize - byte_t'(8));
          mem_wdata  = tag(asize, 1'b1);
          state_next = S_PW2;
        end else begin
          mem_addr     = waddr(bp + sz - byte_t'(8));
          mem_wdata    = tag(sz, 1'b1);
          res_off_next = bp[15:0];
          state_next   = S_DONE;
        end
      end
      S_PW2: begin
        mem_addr   = waddr(bp + asize - byte_t'(4));
        mem_we     = 1'b1;
        mem_wdata  = tag(rem, 1'b0);
        state_next = S_PW3;
      end
      S_PW3: begin
        mem_addr     = waddr(bp + sz - byte_t'(8));
        mem_we       = 1'b1;
        mem_wdata    = tag(rem, 1'b0);
        res_off_next = bp[15:0];
        state_next   = S_DONE;
      end
      S_FWALK_RD: begin
        state_next = (bp >= top) ? S_DONE : S_FWALK_CHK;
      end
      S_FWALK_CHK: begin
        if (rsz < byte_t'(8)) begin
          state_next = S_DONE;
        end else if (bp == byte_t'(off)) begin
          sz_next    = rsz;
          state_next = rdata[0] ? S_FW0 : S_DONE;
        end else if (bp > byte_t'(off)) begin
          state_next = S_DONE;
        end else begin
          bp_next    = bp + rsz;
          state_next = S_FWALK_RD;
        end
      end
      S_FW0: begin
        mem_we     = 1'b1;
        mem_wdata  = tag(sz, 1'b0);
        state_next = S_FW1;
      end
      S_FW1: begin
        mem_addr       = waddr(bp + sz - byte_t'(8));
        mem_we         = 1'b1;
        mem_wdata      = tag(sz, 1'b0);
        grow_mode_next = 1'b0;
        state_next     = S_MPREV;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next              = 1'b1;
          out_data_next.payload_offset = (res_st == ST_OK) ? res_off : '0;
          out_data_next.status         = res_st;
          state_next                  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ilha_chk.sv =====
// port-level checks of the heap allocator and their binding
module ilha_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_offset,
  input logic [1:0]  rsp_status
);
  import ilha_pkg::*;

  // no request taken while the heap is being built after reset
  a_init_hold: assert property (@(posedge clk) $past(rst) |-> !req_ready)
    else $error("request ready during heap build");

  // a failed request never hands out a block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_offset == '0)
    else $error("nonzero offset on failed request");

  // handed out payloads are 8-byte aligned and past the prologue
  a_align: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_OK && rsp_offset != '0
      |-> rsp_offset[2:0] == 3'b000 && rsp_offset >= 16'd16)
    else $error("misaligned payload offset");

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) && $stable(rsp_status))
    else $error("result beat changed while stalled");

endmodule

bind implicit_list_heap_allocator_unit ilha_chk u_ilha_chk (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_offset (rsp.data.payload_offset),
  .rsp_status (rsp.data.status)
);

// ===== dv/tb_implicit_list_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the boundary-tag first-fit heap allocator
module tb_implicit_list_heap_allocator_unit;
  import ilha_pkg::*;

  localparam int HWORDS = 16384;
  localparam int HLIMIT = (HWORDS * 4 > 65536) ? 65536 : HWORDS * 4;
  localparam int WATCHDOG = 200000;

  logic clk;
  logic rst;

  ilha_chan_if #(.T(req_t)) req ();
  ilha_chan_if #(.T(rsp_t)) rsp ();
  ilha_chan_if #(.T(logic [16:0])) cfg ();

  implicit_list_heap_allocator_unit #(.HEAP_WORDS(HWORDS)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // predictor state
  logic [31:0] heap_mem [HWORDS];
  int unsigned heap_end;
  int unsigned chunk_sz;
  rsp_t        expected_q [$];
  logic [15:0] live_blocks [$];

  int  errors;
  int  idle_pct;
  bit  rsp_hold;
  int  quiet_cycles;

  function automatic int unsigned mem_rd(int unsigned b);
    return ((b >> 2) < HWORDS) ? heap_mem[b >> 2] : 0;
  endfunction

  function automatic void mem_wr(int unsigned b, int unsigned v);
    if ((b >> 2) < HWORDS) heap_mem[b >> 2] = v;
  endfunction

  function automatic int unsigned size_of(int unsigned bp);
    return mem_rd(bp - 4) & 32'hFFFF_FFF8;
  endfunction

  function automatic void tag(int unsigned bp, int unsigned sz, int unsigned a);
    mem_wr(bp - 4, sz | a);
    mem_wr(bp + sz - 8, sz | a);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned sz, ptag, nbp, start;
    sz = size_of(bp);
    ptag = mem_rd(bp - 8);
    nbp = bp + sz;
    start = bp;
    if ((mem_rd(nbp - 4) & 1) == 0 && size_of(nbp) >= 8) sz += size_of(nbp);
    if ((ptag & 1) == 0 && (ptag & 32'hFFFF_FFF8) >= 8 && (ptag & 32'hFFFF_FFF8) <= bp) begin
      start = bp - (ptag & 32'hFFFF_FFF8);
      sz += ptag & 32'hFFFF_FFF8;
    end
    tag(start, sz, 0);
    return start;
  endfunction

  function automatic int unsigned grow_heap(int unsigned want);
    int unsigned room, bp;
    room = (HLIMIT > heap_end) ? ((HLIMIT - heap_end) & 32'hFFFF_FFF8) : 0;
    bp = heap_end;
    want = (want + 7) & 32'hFFFF_FFF8;
    if (want > room) want = room;
    if (want < 16) return 0;
    tag(bp, want, 0);
    mem_wr(bp + want - 4, 1);
    heap_end = bp + want;
    return coalesce(bp);
  endfunction

  function automatic void carve(int unsigned bp, int unsigned asz);
    int unsigned csz;
    csz = size_of(bp);
    if (csz - asz >= 16) begin
      tag(bp, asz, 1);
      tag(bp + asz, csz - asz, 0);
    end else begin
      tag(bp, csz, 1);
    end
  endfunction

  function automatic void heap_init();
    int unsigned dummy;
    foreach (heap_mem[i]) heap_mem[i] = 0;
    chunk_sz = CHUNK_RESET;
    mem_wr(4, 9);
    mem_wr(8, 9);
    mem_wr(12, 1);
    heap_end = 16;
    dummy = grow_heap(chunk_sz);
  endfunction

  function automatic rsp_t heap_predict(req_t r);
    rsp_t o;
    int unsigned bp, sz, asz, gb;
    o = '0;
    bp = 16;
    if (r.func == FUNC_FREE) begin
      while (bp < heap_end) begin
        sz = size_of(bp);
        if (sz < 8) break;
        if (bp == r.block_offset) begin
          if (mem_rd(bp - 4) & 1) begin
            tag(bp, sz, 0);
            void'(coalesce(bp));
          end
          break;
        end
        if (bp > r.block_offset) break;
        bp += sz;
      end
      return o;
    end
    if (r.request_bytes == 0) begin
      o.status = ST_ZERO;
      return o;
    end
    asz = (r.request_bytes <= 8) ? 16 : ((r.request_bytes + 15) & 32'hFFFF_FFF8);
    while (bp < heap_end) begin
      sz = size_of(bp);
      if (sz < 8) break;
      if ((mem_rd(bp - 4) & 1) == 0 && sz >= asz) begin
        carve(bp, asz);
        o.payload_offset = bp[15:0];
        return o;
      end
      bp += sz;
    end
    gb = (chunk_sz + 7) & 32'hFFFF_FFF8;
    if (asz > gb) gb = asz;
    bp = grow_heap(gb);
    if (bp == 0 || size_of(bp) < asz) begin
      o.status = ST_OOM;
      return o;
    end
    carve(bp, asz);
    o.payload_offset = bp[15:0];
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // checker of result beats
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat offset=%0d status=%0d",
               rsp.data.payload_offset, rsp.data.status);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp.data.payload_offset !== exp_r.payload_offset) begin
          $error("payload_offset expected %0d actual %0d",
                 exp_r.payload_offset, rsp.data.payload_offset);
          errors++;
        end
        if (rsp.data.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp.data.status);
          errors++;
        end
        if (exp_r.status == ST_OK && exp_r.payload_offset != 0)
          live_blocks.push_back(exp_r.payload_offset);
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("** implicit_list_heap_allocator_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_item(logic func, logic [15:0] rbytes, logic [15:0] boff);
    req_t r;
    r.func = func;
    r.request_bytes = rbytes;
    r.block_offset = boff;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back(heap_predict(r));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_chunk(logic [16:0] v);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    chunk_sz = 32'(v);
    cfg.valid <= 1'b0;
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(live_blocks.size() - 1);
    send_item(FUNC_FREE, 16'($urandom), live_blocks[k]);
    live_blocks.delete(k);
  endtask

  task automatic test_directed();
    send_item(FUNC_ALLOC, 16'd0, 16'hFFFF);
    send_item(FUNC_ALLOC, 16'd1, 16'd0);
    send_item(FUNC_ALLOC, 16'd8, 16'd0);
    send_item(FUNC_ALLOC, 16'd9, 16'd0);
    send_item(FUNC_ALLOC, 16'd100, 16'd0);
    send_item(FUNC_ALLOC, 16'd5000, 16'd0);
    send_item(FUNC_FREE, 16'hFFFF, 16'd8);
    send_item(FUNC_FREE, 16'd0, 16'd16);
    send_item(FUNC_FREE, 16'd0, 16'd16);
    send_item(FUNC_FREE, 16'd0, 16'd40);
    send_item(FUNC_FREE, 16'd0, 16'hFFFF);
    send_item(FUNC_ALLOC, 16'd24, 16'd0);
    send_item(FUNC_ALLOC, 16'hFFFF, 16'd0);
    send_item(FUNC_ALLOC, 16'd30000, 16'd0);
    send_item(FUNC_ALLOC, 16'd30000, 16'd0);
    send_item(FUNC_ALLOC, 16'd2000, 16'd0);
    drain();
  endtask

  task automatic test_random(int n, int maxreq);
    repeat (n) begin
      if (live_blocks.size() != 0 && $urandom_range(99) < 45) free_live();
      else if ($urandom_range(99) < 5)
        send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      else send_item(FUNC_ALLOC, 16'($urandom_range(maxreq, 1)), 16'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    rsp_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rsp_hold = 1'b0;
      end
      repeat (20) send_item(FUNC_ALLOC, 16'($urandom_range(64, 1)), 16'd0);
    join
    drain();
  endtask

  task automatic test_free_all();
    while (live_blocks.size() != 0) begin
      free_live();
      if (live_blocks.size() == 0) drain();
    end
    drain();
  endtask

  initial begin
    errors = 0;
    idle_pct = 35;
    rsp_hold = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    heap_init();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 256);
    write_chunk(17'd16);
    test_random(250, 64);
    write_chunk(17'h1FFFF);
    test_random(150, 4000);
    test_free_all();
    write_chunk(17'd100);
    idle_pct = 0;
    test_random(300, 200);
    idle_pct = 35;
    test_backpressure();
    write_chunk(17'd4096);
    test_random(400, 1024);
    test_free_all();
    if (errors == 0) $display("** implicit_list_heap_allocator_unit: PASSED **");
    else $display("** implicit_list_heap_allocator_unit: FAILED **");
    $finish;
  end
endmodule
